>>> rtl/mhs_pkg.sv
// mhs_pkg: shared constants, types and command structs for the modexp hash block
// used by every module under rtl; has no dependencies of its own
package mhs_pkg;

  // field widths
  localparam int unsigned HOST_W     = 32;
  localparam int unsigned USEC_W     = 20;
  localparam int unsigned RAND_W     = 64;
  localparam int unsigned SEED_W     = 60;
  localparam int unsigned HASH_W     = 31;
  localparam int unsigned PROD_W     = 2 * HASH_W;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 31;
  localparam int unsigned CNT_W      = 2;

  // barrett reduction widths: quotient estimate, its product, residue before fold
  localparam int unsigned QT_W  = HASH_W + 1;
  localparam int unsigned MQ_W  = 2 * QT_W;
  localparam int unsigned RED_W = HASH_W + 2;

  // seed mixing shifts
  localparam int unsigned HOST_SHIFT = 24;
  localparam int unsigned USEC_SHIFT = 4;

  // modulus and generator
  localparam logic [HASH_W-1:0] PRIME_MOD = 31'd2001001003;
  localparam logic [HASH_W-1:0] GEN_BASE  = 31'd4011;
  localparam logic [HASH_W-1:0] HASH_ONE  = 31'd1;

  // floor(2^62 / modulus) for the quotient estimate
  localparam logic [QT_W-1:0] BARRETT_M =
    QT_W'((MQ_W'(1) << (2 * HASH_W)) / MQ_W'(PRIME_MOD));

  // pipeline stages of the modular multiplier after the operand register
  localparam int unsigned MUL_STAGES = 3;

  // sequencer wait limits
  localparam logic [CNT_W-1:0] RED_LAST = CNT_W'(MUL_STAGES - 1);
  localparam logic [CNT_W-1:0] MM_LAST  = CNT_W'(MUL_STAGES - 1);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SELECT_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROB_NUM      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PROB_DEN      = 2'd2;

  // configuration reset values
  localparam logic [CFG_DATA_W-1:0] PROB_NUM_RESET = 31'd1;
  localparam logic [CFG_DATA_W-1:0] PROB_DEN_RESET = 31'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_EXP_INIT,
    ST_EXP_CHECK,
    ST_MM_RUN,
    ST_EXP_UPD,
    ST_CMP_MUL,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic load_seed;
    logic exp_init;
    logic mm_start;
    logic exp_update;
    logic cmp_mul;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic exp_zero;
  } stat_t;

  typedef struct packed {
    logic                  select_enable;
    logic [CFG_DATA_W-1:0] prob_numerator;
    logic [CFG_DATA_W-1:0] prob_denominator;
  } cfg_t;

endpackage

>>> rtl/mhs_modmul.sv
// mhs_modmul: pipelined modular multiplier, full product then barrett reduction
// depends on mhs_pkg for the modulus, the reduction constant and widths
module mhs_modmul (
  input  logic                       clk,
  input  logic                       start,
  input  logic                       raw,
  input  logic [mhs_pkg::HASH_W-1:0] a_in,
  input  logic [mhs_pkg::HASH_W-1:0] b_in,
  input  logic [mhs_pkg::SEED_W-1:0] x_in,
  output logic [mhs_pkg::HASH_W-1:0] product
);
  import mhs_pkg::*;

  localparam logic [RED_W-1:0] FOLD_ONE = {2'b00, PRIME_MOD};
  localparam logic [RED_W-1:0] FOLD_TWO = {1'b0, PRIME_MOD, 1'b0};

  logic [PROD_W-1:0] x;
  logic [MQ_W-1:0]   q_full;
  logic [QT_W-1:0]   q;
  logic [RED_W-1:0]  qp;
  logic [RED_W-1:0]  diff;

  // quotient estimate from the top 32 bits of the value
  assign q_full = MQ_W'(x[PROD_W-1:HASH_W-1]) * MQ_W'(BARRETT_M);

  // residue below 3p, fold back with one or two subtractions
  always_comb begin
    if (diff >= FOLD_TWO) begin
      product = HASH_W'(diff - FOLD_TWO);
    end else if (diff >= FOLD_ONE) begin
      product = HASH_W'(diff - FOLD_ONE);
    end else begin
      product = HASH_W'(diff);
    end
  end

  // value register, then quotient, quotient times modulus, residue
  always_ff @(posedge clk) begin
    if (start) begin
      x <= raw ? PROD_W'(x_in) : PROD_W'(a_in) * PROD_W'(b_in);
    end
    q    <= q_full[MQ_W-1:QT_W];
    qp   <= RED_W'(q) * RED_W'(PRIME_MOD);
    diff <= x[RED_W-1:0] - qp;
  end

endmodule

>>> rtl/mhs_dp.sv
// mhs_dp: datapath for seed mixing, seed reduction, exponentiation and selection
// depends on mhs_pkg and mhs_modmul
module mhs_dp (
  input  logic                       clk,
  input  mhs_pkg::cmd_t              cmd,
  output mhs_pkg::stat_t             stat,
  input  mhs_pkg::cfg_t              cfg,
  input  logic [mhs_pkg::HOST_W-1:0] host_id,
  input  logic [mhs_pkg::USEC_W-1:0] micro_seconds,
  input  logic [mhs_pkg::RAND_W-1:0] random_word,
  output logic [mhs_pkg::HASH_W-1:0] hash_value,
  output logic                       active
);
  import mhs_pkg::*;

  logic [SEED_W-1:0] seed_mix;
  logic [HASH_W-1:0] expo;
  logic [HASH_W-1:0] base;
  logic [HASH_W-1:0] acc;
  logic [HASH_W-1:0] acc_prod;
  logic [HASH_W-1:0] sq_prod;
  logic [PROD_W-1:0] lhs;
  logic [PROD_W-1:0] rhs;

  // seed mix modulo 2^60, top four bits of the random word dropped
  assign seed_mix = SEED_W'({host_id, HOST_SHIFT'(0)})
                  + SEED_W'({micro_seconds, USEC_SHIFT'(0)})
                  + random_word[SEED_W-1:0];

  // two multipliers per exponent bit: acc*base and base*base
  mhs_modmul u_mul_acc (
    .clk     (clk),
    .start   (cmd.mm_start),
    .raw     (1'b0),
    .a_in    (acc),
    .b_in    (base),
    .x_in    ('0),
    .product (acc_prod)
  );

  // the squaring unit also reduces the raw seed when a transaction is taken
  mhs_modmul u_mul_sq (
    .clk     (clk),
    .start   (cmd.mm_start || cmd.load_seed),
    .raw     (cmd.load_seed),
    .a_in    (base),
    .b_in    (base),
    .x_in    (seed_mix),
    .product (sq_prod)
  );

  // exponent, base and accumulator registers
  always_ff @(posedge clk) begin
    if (cmd.exp_init) begin
      expo <= sq_prod;
      base <= GEN_BASE;
      acc  <= HASH_ONE;
    end else if (cmd.exp_update) begin
      expo <= {1'b0, expo[HASH_W-1:1]};
      base <= sq_prod;
      if (expo[0]) begin
        acc <= acc_prod;
      end
    end
  end

  // selection products, then compare into the output register
  always_ff @(posedge clk) begin
    if (cmd.cmp_mul) begin
      lhs <= PROD_W'(acc) * PROD_W'(cfg.prob_denominator);
      rhs <= PROD_W'(cfg.prob_numerator) * PROD_W'(PRIME_MOD);
    end
    if (cmd.out_load) begin
      hash_value <= acc;
      active     <= !cfg.select_enable || (lhs < rhs);
    end
  end

  assign stat.exp_zero = (expo == '0);

endmodule

>>> rtl/mhs_ctrl.sv
// mhs_ctrl: sequencer for the modexp hash block, handshakes and step counts
// depends on mhs_pkg for state and command types
module mhs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  mhs_pkg::stat_t    stat,
  output mhs_pkg::cmd_t     cmd,
  output mhs_pkg::state_t   state
);
  import mhs_pkg::*;

  state_t           state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             out_free;

  assign out_free = !out_valid || out_ready;

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:      if (in_valid) state_next = ST_REDUCE;
      ST_REDUCE:    if (cnt == RED_LAST) state_next = ST_EXP_INIT;
      ST_EXP_INIT:  state_next = ST_EXP_CHECK;
      ST_EXP_CHECK: state_next = stat.exp_zero ? ST_CMP_MUL : ST_MM_RUN;
      ST_MM_RUN:    if (cnt == MM_LAST) state_next = ST_EXP_UPD;
      ST_EXP_UPD:   state_next = ST_EXP_CHECK;
      ST_CMP_MUL:   state_next = ST_FINISH;
      ST_FINISH:    if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.load_seed = in_valid;
      end
      ST_EXP_INIT:  cmd.exp_init   = 1'b1;
      ST_EXP_CHECK: cmd.mm_start   = !stat.exp_zero;
      ST_EXP_UPD:   cmd.exp_update = 1'b1;
      ST_CMP_MUL:   cmd.cmp_mul    = 1'b1;
      ST_FINISH:    cmd.out_load   = out_free;
      default:      cmd            = '0;
    endcase
  end

  // wait counter runs only while a multiply is in the pipeline
  assign cnt_next = (state == ST_REDUCE || state == ST_MM_RUN) ? cnt + 1'b1 : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/modexp_hash_sample_select.sv
// modexp_hash_sample_select: top level, configuration registers and assertions
// depends on mhs_pkg, mhs_ctrl, mhs_dp (and mhs_modmul below it)
//
//   channel  signals                                     direction
//   input    in_valid/in_ready, host_id, micro_seconds,   in
//            random_word
//   output   out_valid/out_ready, hash_value, active      out
//   config   cfg_write, cfg_index, cfg_data               in
//
// one transaction at a time: seed reduction, then one pass of the exponent
// loop per exponent bit up to the highest set bit (31 at most), plus the
// accept, setup, compare and handoff steps; each loop pass waits on the
// three-stage modular multipliers. rst is synchronous: it clears the
// sequencer and loads register defaults. a result held by out_ready low
// stalls only the final handoff; the next input transaction is taken as
// soon as the result is registered.
module modexp_hash_sample_select (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [mhs_pkg::HOST_W-1:0]     host_id,
  input  logic [mhs_pkg::USEC_W-1:0]     micro_seconds,
  input  logic [mhs_pkg::RAND_W-1:0]     random_word,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [mhs_pkg::HASH_W-1:0]     hash_value,
  output logic                           active,
  input  logic                           cfg_write,
  input  logic [mhs_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mhs_pkg::CFG_DATA_W-1:0] cfg_data
);
  import mhs_pkg::*;

  cfg_t   cfg;
  cmd_t   cmd;
  stat_t  stat;
  state_t state;

  // configuration registers, unknown indexes ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.select_enable    <= 1'b0;
      cfg.prob_numerator   <= PROB_NUM_RESET;
      cfg.prob_denominator <= PROB_DEN_RESET;
    end else if (cfg_write) begin
      if (cfg_index == REG_SELECT_ENABLE) begin
        cfg.select_enable <= cfg_data[0];
      end
      if (cfg_index == REG_PROB_NUM) begin
        cfg.prob_numerator <= cfg_data;
      end
      if (cfg_index == REG_PROB_DEN) begin
        cfg.prob_denominator <= cfg_data;
      end
    end
  end

  mhs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (stat),
    .cmd       (cmd),
    .state     (state)
  );

  mhs_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .stat          (stat),
    .cfg           (cfg),
    .host_id       (host_id),
    .micro_seconds (micro_seconds),
    .random_word   (random_word),
    .hash_value    (hash_value),
    .active        (active)
  );

  // a delivered hash is always a residue of the prime
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (hash_value < PRIME_MOD))
    else $error("hash value not reduced");

  // an accepted input always starts the seed reduction
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> (state == ST_REDUCE))
    else $error("accepted input did not start reduction");

  // a taken result clears unless a new one is loaded in the same cycle
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && state != ST_FINISH) |=> !out_valid)
    else $error("result repeated after transaction");

  // input is never taken while the sequencer is busy
  assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> !in_ready)
    else $error("input ready while busy");

endmodule
